// ----- rtl/roulette_wheel_parent_selector_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Roulette wheel parent selector: assertion macros
// Shared concurrent assertion forms, sampled on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_PARENT_SELECTOR_UNIT_DEFINES_SVH
`define ROULETTE_WHEEL_PARENT_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RWPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RWPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rwps_pkg.sv -----
// ----------------------------------------------------------------------------
// rwps_pkg
// Shared widths, kind codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rwps_pkg;

   localparam int POP_SIZE_DEF = 256;

   localparam int FIT_W    = 24;
   localparam int FRAC_W   = 16;
   localparam int TOTAL_W  = 32;
   localparam int KIND_W   = 2;
   localparam int OIDX_W   = 8;
   localparam int OCNT_W   = 9;
   localparam int PROD_W   = FRAC_W + TOTAL_W;

   localparam int REQ_FIELDS_W = FIT_W + FRAC_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = OIDX_W + 1 + TOTAL_W + OIDX_W + FIT_W + OCNT_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

   typedef struct packed {
      logic capture;
      logic exec;
      logic mul;
      logic walk;
      logic emit;
   } rwps_cmd_type;

   typedef struct packed {
      logic is_draw;
      logic empty;
      logic hit;
      logic last;
      logic out_free;
   } rwps_sts_type;

endpackage

// ----- rtl/roulette_wheel_parent_selector_unit.sv -----
// ----------------------------------------------------------------------------
// roulette_wheel_parent_selector_unit
// A clear, load or draw beat on req_ gives one result beat on rsp_. A clear
// or load is executed and its result emitted. A draw is executed, scaled in
// a multiply step, then walks the loaded members (none for an empty
// population) until one is picked or the last member is reached: the walk
// reads one stored fitness per cycle from the population RAM. One beat is in
// work at a time; a new beat is accepted while the previous result waits on rsp_.
// ----------------------------------------------------------------------------
module roulette_wheel_parent_selector_unit #(
   parameter int POP_SIZE = rwps_pkg::POP_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fitness_value[23:0], random_fraction[39:24]
   input  logic [rwps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind[1:0]
   input  logic [rwps_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // chosen_index[7:0], chosen_valid[8], total_fitness[40:9], best_index[48:41],
   // best_fitness[72:49], member_count[81:73], load_refused[82], zero[87:83]
   output logic [rwps_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rwps_pkg::*;

   rwps_cmd_type cmd;
   rwps_sts_type sts;

   rwps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rwps_datapath #(
      .POP_SIZE (POP_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/rwps_ram.sv -----
// ----------------------------------------------------------------------------
// rwps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rwps_ctrl.sv -----
// ----------------------------------------------------------------------------
// rwps_ctrl
// Sequencer: capture, execute, for a draw scale and walk the population, emit the result.
// ----------------------------------------------------------------------------
module rwps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output rwps_pkg::rwps_cmd_type cmd,
   input  rwps_pkg::rwps_sts_type sts
);
   import rwps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_WALK,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.is_draw ? ST_MUL : ST_EMIT;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = sts.empty ? ST_EMIT : ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.hit || sts.last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

endmodule

// ----- rtl/rwps_datapath.sv -----
// ----------------------------------------------------------------------------
// rwps_datapath
// Population store, running total, best member, draw scaling and walk,
// result register.
// ----------------------------------------------------------------------------
module rwps_datapath #(
   parameter int POP_SIZE = rwps_pkg::POP_SIZE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rwps_pkg::rwps_cmd_type            cmd,
   output rwps_pkg::rwps_sts_type            sts,
   input  logic [rwps_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [rwps_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rwps_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   `include "roulette_wheel_parent_selector_unit_defines.svh"
   import rwps_pkg::*;

   localparam int IDX_W = $clog2(POP_SIZE);
   localparam int CNT_W = $clog2(POP_SIZE + 1);

   // captured beat
   logic [KIND_W-1:0]  kind_ff;
   logic [FIT_W-1:0]   fit_ff;
   logic [FRAC_W-1:0]  frac_ff;

   // population state
   logic [CNT_W-1:0]   count_ff,    count_in;
   logic [TOTAL_W-1:0] total_ff,    total_in;
   logic [OIDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [FIT_W-1:0]   best_fit_ff, best_fit_in;
   logic               refused_ff,  refused_in;

   // draw
   logic [TOTAL_W-1:0] rem_ff,      rem_in;
   logic [CNT_W-1:0]   walk_cnt_ff, walk_cnt_in;
   logic               found_ff,    found_in;

   // result register
   logic                  out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic                  full;
   logic                  do_load;
   logic                  refuse_now;
   logic [TOTAL_W:0]      sum;
   logic [PROD_W-1:0]     prod;
   logic [FIT_W-1:0]      ram_rdata;
   logic [CNT_W+OIDX_W-1:0] cnt_ext;
   logic [CNT_W+OIDX_W-1:0] walk_ext;
   logic [CNT_W+OCNT_W-1:0] cnt_ext9;
   logic [OIDX_W-1:0]     chosen_idx;
   logic [RSP_FIELDS_W-1:0] rsp_fields;

   assign full       = (count_ff >= CNT_W'(POP_SIZE));
   assign do_load    = cmd.exec && (kind_ff == KIND_LOAD) && !full;
   assign refuse_now = cmd.exec && (kind_ff == KIND_LOAD) && full;
   assign sum        = {1'b0, total_ff} + (TOTAL_W + 1)'(fit_ff);
   assign prod       = PROD_W'(frac_ff) * PROD_W'(total_ff);
   assign cnt_ext    = {{OIDX_W{1'b0}}, count_ff};
   assign walk_ext   = {{OIDX_W{1'b0}}, walk_cnt_ff};
   assign cnt_ext9   = {{OCNT_W{1'b0}}, count_ff};

   rwps_ram #(
      .WIDTH (FIT_W),
      .DEPTH (POP_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (fit_ff),
      .rd_addr (walk_cnt_in[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign sts.is_draw  = (kind_ff == KIND_DRAW);
   assign sts.empty    = (count_ff == '0);
   assign sts.hit      = (rem_ff < TOTAL_W'(ram_rdata));
   assign sts.last     = ((walk_cnt_ff + CNT_W'(1)) == count_ff);
   assign sts.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      count_in    = count_ff;
      total_in    = total_ff;
      best_idx_in = best_idx_ff;
      best_fit_in = best_fit_ff;
      refused_in  = refused_ff;
      rem_in      = rem_ff;
      walk_cnt_in = walk_cnt_ff;
      found_in    = found_ff;

      if (cmd.capture) begin
         refused_in = 1'b0;
         found_in   = 1'b0;
      end

      if (cmd.exec) begin
         case (kind_ff)
            KIND_CLEAR: begin
               count_in    = '0;
               total_in    = '0;
               best_idx_in = '0;
               best_fit_in = '0;
            end
            KIND_LOAD: begin
               if (full) begin
                  refused_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  total_in = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                  if (fit_ff > best_fit_ff) begin
                     best_fit_in = fit_ff;
                     best_idx_in = cnt_ext[OIDX_W-1:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.mul) begin
         rem_in      = prod[PROD_W-1:FRAC_W];
         walk_cnt_in = '0;
         found_in    = 1'b0;
      end

      if (cmd.walk) begin
         if (sts.hit) begin
            found_in = 1'b1;
         end else if (!sts.last) begin
            rem_in      = rem_ff - TOTAL_W'(ram_rdata);
            walk_cnt_in = walk_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser;
         fit_ff  <= req_tdata[FIT_W-1:0];
         frac_ff <= req_tdata[FIT_W+FRAC_W-1:FIT_W];
      end
      rem_ff      <= rem_in;
      walk_cnt_ff <= walk_cnt_in;
      if (cmd.emit) begin
         out_data_ff <= RSP_DATA_W'(rsp_fields);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         best_idx_ff  <= '0;
         best_fit_ff  <= '0;
         refused_ff   <= 1'b0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         total_ff    <= total_in;
         best_idx_ff <= best_idx_in;
         best_fit_ff <= best_fit_in;
         refused_ff  <= refused_in;
         found_ff    <= found_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign chosen_idx = found_ff ? walk_ext[OIDX_W-1:0] : '0;
   assign rsp_fields = {refused_ff, cnt_ext9[OCNT_W-1:0], best_fit_ff, best_idx_ff,
                        total_ff, found_ff, chosen_idx};

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `RWPS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(POP_SIZE), "count over capacity")
   `RWPS_ASSERT_NEXT(a_refused_hold, refuse_now, $stable(count_ff) && refused_ff, "refused load")
   `RWPS_ASSERT_NOW(a_walk_range, cmd.walk, walk_cnt_ff < count_ff, "walk past loaded members")
   `RWPS_ASSERT_NOW(a_emit_free, cmd.emit, !out_valid_ff || rsp_tready, "result overwritten")

endmodule

// ----- dv/roulette_wheel_parent_selector_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_parent_selector_unit_tb
// Self-checking bench for the roulette wheel parent selector. A scoreboard
// class keeps its own copy of the population, running total and best member.
// For every accepted request beat it predicts the result beat. Each response
// beat is checked field by field against the oldest prediction. Stimulus opens
// with directed corner cases. It then runs random clear/load/draw sequences:
// full populations, refused loads, ties, zero fitness and spare kinds. Both
// sides idle at random, with one long response stall and several drain pauses.
// ----------------------------------------------------------------------------
module roulette_wheel_parent_selector_unit_tb;
   import rwps_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int ITEM_TARGET = 1800;
   localparam int STALL_AFTER = 500;
   localparam int STALL_LEN   = 400;
   localparam int TAIL_CYCLES = 300;

   // rsp_tdata layout, msb first
   typedef struct packed {
      logic [4:0]         pad;
      logic               load_refused;
      logic [OCNT_W-1:0]  member_count;
      logic [FIT_W-1:0]   best_fitness;
      logic [OIDX_W-1:0]  best_index;
      logic [TOTAL_W-1:0] total_fitness;
      logic               chosen_valid;
      logic [OIDX_W-1:0]  chosen_index;
   } rsp_fields_type;

   class selection_scoreboard_type;
      logic [FIT_W-1:0]   fitness_mem [POP_SIZE_DEF];
      logic [OCNT_W-1:0]  loaded;
      logic [TOTAL_W-1:0] total;
      logic [OIDX_W-1:0]  top_idx;
      logic [FIT_W-1:0]   top_fit;
      rsp_fields_type     expected_beats [$];
      int mismatches, checked;
      int n_clear, n_load, n_refused, n_draw, n_picked, n_spare, max_loaded;

      function new();
         loaded = '0;
         total = '0;
         top_idx = '0;
         top_fit = '0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [FIT_W-1:0] fit,
                                 logic [FRAC_W-1:0] frac);
         rsp_fields_type want;
         logic [TOTAL_W:0] sum;
         logic [PROD_W-1:0] remain;
         int i;
         want = '0;
         case (kind)
            KIND_CLEAR: begin
               n_clear++;
               loaded = '0;
               total = '0;
               top_idx = '0;
               top_fit = '0;
            end
            KIND_LOAD: begin
               n_load++;
               if (loaded >= POP_SIZE_DEF) begin
                  want.load_refused = 1'b1;
                  n_refused++;
               end else begin
                  fitness_mem[loaded] = fit;
                  sum = {1'b0, total} + (TOTAL_W+1)'(fit);
                  total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                  if (fit > top_fit) begin
                     top_fit = fit;
                     top_idx = loaded[OIDX_W-1:0];
                  end
                  loaded++;
                  if (loaded > max_loaded) max_loaded = loaded;
               end
            end
            KIND_DRAW: begin
               n_draw++;
               remain = (PROD_W'(frac) * PROD_W'(total)) >> FRAC_W;
               for (i = 0; i < loaded; i++) begin
                  if (remain < PROD_W'(fitness_mem[i])) begin
                     want.chosen_index = OIDX_W'(i);
                     want.chosen_valid = 1'b1;
                     n_picked++;
                     break;
                  end
                  remain -= PROD_W'(fitness_mem[i]);
               end
            end
            default: n_spare++;
         endcase
         want.total_fitness = total;
         want.best_index    = top_idx;
         want.best_fitness  = top_fit;
         want.member_count  = loaded;
         expected_beats.push_back(want);
      endfunction

      function void compare(string name, longint unsigned exp_val, longint unsigned act_val);
         if (exp_val != act_val) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] beat);
         rsp_fields_type got, want;
         got = rsp_fields_type'(beat);
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing outstanding: %h", beat);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         checked++;
         compare("chosen_index",  want.chosen_index,  got.chosen_index);
         compare("chosen_valid",  want.chosen_valid,  got.chosen_valid);
         compare("total_fitness", want.total_fitness, got.total_fitness);
         compare("best_index",    want.best_index,    got.best_index);
         compare("best_fitness",  want.best_fitness,  got.best_fitness);
         compare("member_count",  want.member_count,  got.member_count);
         compare("load_refused",  want.load_refused,  got.load_refused);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   selection_scoreboard_type sb;
   int items_sent;
   int calm_left [2];
   bit calm_on [2];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   roulette_wheel_parent_selector_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // side 0: request, side 1: response; calm stretches run with no gaps
   function automatic int pick_gap(int side);
      if (calm_left[side] == 0) begin
         calm_on[side] = ($urandom_range(0, 3) == 0);
         calm_left[side] = $urandom_range(20, 80);
      end
      calm_left[side]--;
      return calm_on[side] ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic [FIT_W-1:0] pick_fitness(int style);
      case (style)
         0: return FIT_W'($urandom);
         1: return FIT_W'($urandom_range(0, 255));
         2: case ($urandom_range(0, 3))
               0: return '0;
               1: return 24'h010000;
               2: return 24'h7FFFFF;
               default: return '1;
            endcase
         default: return FIT_W'($urandom) >> $urandom_range(0, 23);
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] pick_fraction();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return FRAC_W'($urandom);
      endcase
   endfunction

   task automatic send_beat(logic [KIND_W-1:0] kind, logic [FIT_W-1:0] fit,
                            logic [FRAC_W-1:0] frac);
      int gap;
      gap = pick_gap(0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {frac, fit};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, fit, frac);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
   endtask

   task automatic fill_population(bit ascending);
      int i;
      send_beat(KIND_CLEAR, FIT_W'($urandom), FRAC_W'($urandom));
      for (i = 0; i < POP_SIZE_DEF; i++)
         send_beat(KIND_LOAD, ascending ? {8'(i), 16'($urandom)} : pick_fitness(i % 4),
                   FRAC_W'($urandom));
      repeat ($urandom_range(1, 3))
         send_beat(KIND_LOAD, FIT_W'($urandom), FRAC_W'($urandom));
      send_beat(KIND_DRAW, FIT_W'($urandom), '0);
      send_beat(KIND_DRAW, FIT_W'($urandom), '1);
      send_beat(KIND_SPARE, FIT_W'($urandom), FRAC_W'($urandom));
      repeat (4) send_beat(KIND_DRAW, FIT_W'($urandom), FRAC_W'($urandom));
   endtask

   task automatic run_sequence();
      int style, n_loads, n_draws;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any kind, any data
         repeat ($urandom_range(1, 4))
            send_beat(KIND_W'($urandom), FIT_W'($urandom), FRAC_W'($urandom));
         return;
      end
      style = $urandom_range(0, 3);
      n_loads = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      n_draws = $urandom_range(1, 8);
      if ($urandom_range(0, 5) != 0)
         send_beat(KIND_CLEAR, FIT_W'($urandom), FRAC_W'($urandom));
      repeat (n_loads) send_beat(KIND_LOAD, pick_fitness(style), FRAC_W'($urandom));
      repeat (n_draws) begin
         if ($urandom_range(0, 9) == 0)
            send_beat(KIND_LOAD, pick_fitness(style), FRAC_W'($urandom));
         send_beat(KIND_DRAW, FIT_W'($urandom), pick_fraction());
      end
   endtask

   // response side
   initial begin
      int hold;
      bit stalled;
      stalled = 1'b0;
      wait (reset == 1'b0);
      forever begin
         hold = pick_gap(1);
         if (!stalled && sb.checked >= STALL_AFTER) begin
            stalled = 1'b1;
            hold = STALL_LEN;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int seq_no;
      sb = new();
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_CLEAR;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_beat(KIND_DRAW,  24'h123456, 16'h8000);   // empty population
      send_beat(KIND_SPARE, 24'hFFFFFF, 16'hFFFF);
      send_beat(KIND_LOAD,  24'h000000, 16'hFFFF);   // zero fitness, best stays 0
      send_beat(KIND_DRAW,  24'hFFFFFF, 16'hFFFF);   // zero total
      send_beat(KIND_LOAD,  24'hFFFFFF, 16'h0000);
      send_beat(KIND_LOAD,  24'hFFFFFF, 16'h0000);   // tie keeps the first
      send_beat(KIND_LOAD,  24'h000001, 16'h5555);
      send_beat(KIND_DRAW,  24'h000000, 16'h0000);
      send_beat(KIND_DRAW,  24'h000000, 16'hFFFF);
      send_beat(KIND_DRAW,  24'hAAAAAA, 16'h0001);
      send_beat(KIND_SPARE, 24'h000000, 16'h0000);
      send_beat(KIND_CLEAR, 24'h555555, 16'hAAAA);
      send_beat(KIND_DRAW,  24'hFFFFFF, 16'h7FFF);   // after clear
      send_beat(KIND_LOAD,  24'hAAAAAA, 16'h0000);
      send_beat(KIND_LOAD,  24'h555555, 16'hFFFF);
      send_beat(KIND_LOAD,  24'h800000, 16'h0000);
      send_beat(KIND_LOAD,  24'h000000, 16'h0000);
      send_beat(KIND_DRAW,  24'h000000, 16'hAAAA);
      send_beat(KIND_DRAW,  24'h000000, 16'h5555);
      send_beat(KIND_DRAW,  24'h000000, 16'hFFFF);
      drain_results();

      fill_population(1'b1);
      drain_results();
      seq_no = 0;
      while (items_sent < ITEM_TARGET) begin
         seq_no++;
         if (seq_no == 40) fill_population(1'b0);
         run_sequence();
         if ($urandom_range(0, 11) == 0) drain_results();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d request beats: %0d clears, %0d loads (%0d refused), %0d spare kinds",
               items_sent, sb.n_clear, sb.n_load, sb.n_refused, sb.n_spare);
      $display("%0d draws, %0d picked a parent; largest population %0d; %0d results checked",
               sb.n_draw, sb.n_picked, sb.max_loaded, sb.checked);
      if (sb.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rwps_pkg.sv
rtl/rwps_ram.sv
rtl/rwps_ctrl.sv
rtl/rwps_datapath.sv
rtl/roulette_wheel_parent_selector_unit.sv
dv/roulette_wheel_parent_selector_unit_tb.sv
